### sv/sidec_pkg.sv
// ----------------------------------------------------------------------------
// sidec_pkg
// Shared widths, character codes and controller/datapath interface types for
// the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sidec_pkg;

    // Field and storage widths
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 6;
    localparam int NUM_DIGITS  = 10;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int ITER_W      = $clog2(VALUE_W);

    // Last shift-add-3 iteration index
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(VALUE_W - 1);

    // Double dabble correction
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;

    // ASCII codes (6-bit)
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture input, form magnitude
        logic shift;       // one shift-add-3 iteration
        logic init_idx;    // point at leading significant digit
        logic emit_sign;   // load '-' into output register
        logic emit_digit;  // load current digit into output register
    } sidec_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic neg;         // input was negative
        logic last_digit;  // digit pointer at least significant digit
        logic out_free;    // output register can take a character
    } sidec_status_t;

endpackage

### sv/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output transaction, leading '-' for negatives, no leading zeros.
//
//   Channel   Ports                           Direction  Content
//   s_        s_valid s_ready s_value         in         integer, 32b signed
//   m_        m_valid m_ready m_character     out        ASCII char + last flag
//             m_last
//
// An accepted value runs through the shift-add-3 loop, then the leading digit
// is located, then one character per cycle is emitted while the output
// register is free; the sequencer returns to idle after the last digit.
// A stalled m_ready holds the output register and pauses character issue.
// s_ready is high only while the sequencer is idle; reset clears the
// sequencer and the output valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [sidec_pkg::VALUE_W-1:0] s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [sidec_pkg::CHAR_W-1:0]  m_character,
    output logic                                 m_last
);
    import sidec_pkg::*;

    sidec_cmd_t    cmd;
    sidec_status_t status;

    // Sequencer
    sidec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Conversion and output datapath
    sidec_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .m_character (m_character),
        .m_last      (m_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    // The minus sign never ends a number
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_character == CHAR_MINUS) |-> !m_last)
        else $error("minus sign flagged as last character");

    // A number in progress keeps the input side closed
    a_busy_mid_number: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> !s_ready)
        else $error("input ready while a number is still being emitted");

    // An accepted transaction takes the block busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after an accepted transaction");

endmodule

### sv/sidec_dpath.sv
// ----------------------------------------------------------------------------
// sidec_dpath
// Magnitude and BCD registers, shift-add-3 iteration, digit pointer and the
// output character register.
// ----------------------------------------------------------------------------
module sidec_dpath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [sidec_pkg::VALUE_W-1:0] s_value,
    output logic        [sidec_pkg::CHAR_W-1:0]  m_character,
    output logic                                 m_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    input  sidec_pkg::sidec_cmd_t                cmd,
    output sidec_pkg::sidec_status_t             status
);
    import sidec_pkg::*;

    logic [VALUE_W-1:0]     mag_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic                   neg_reg;
    logic [DIGIT_IDX_W-1:0] idx_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;
    logic                   valid_reg;

    logic [BCD_W-1:0]       bcd_adj;
    logic [DIGIT_IDX_W-1:0] lead_idx;
    logic [DIGIT_W-1:0]     cur_digit;
    logic [VALUE_W-1:0]     raw_value;
    logic [VALUE_W-1:0]     load_mag;

    // Magnitude without overflow: unsigned negate covers the most negative value
    assign raw_value = VALUE_W'(s_value);
    assign load_mag  = raw_value[VALUE_W-1] ? (VALUE_W'(0) - raw_value) : raw_value;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Highest nonzero digit; zero keeps a single digit
    always_comb begin
        lead_idx = '0;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] != '0) begin
                lead_idx = DIGIT_IDX_W'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[{idx_reg, 2'b00} +: DIGIT_W];

    // Conversion registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg <= load_mag;
            bcd_reg <= '0;
            neg_reg <= raw_value[VALUE_W-1];
        end else if (cmd.shift) begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_reg <= {mag_reg[VALUE_W-2:0], 1'b0};
        end
    end

    // Digit pointer, walks down from the leading digit
    always_ff @(posedge aclk) begin
        if (cmd.init_idx) begin
            idx_reg <= lead_idx;
        end else if (cmd.emit_digit && idx_reg != '0) begin
            idx_reg <= idx_reg - DIGIT_IDX_W'(1);
        end
    end

    // Output character register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            char_reg <= CHAR_ZERO + CHAR_W'(cur_digit);
            last_reg <= (idx_reg == '0);
        end
    end

    assign m_character       = char_reg;
    assign m_last            = last_reg;
    assign m_valid           = valid_reg;
    assign status.neg        = neg_reg;
    assign status.last_digit = (idx_reg == '0);
    assign status.out_free   = !valid_reg || m_ready;

endmodule

### sv/sidec_ctrl.sv
// ----------------------------------------------------------------------------
// sidec_ctrl
// Sequencer: accepts a value, runs the shift-add-3 iterations, then issues
// the sign and digit characters as the output register frees up.
// ----------------------------------------------------------------------------
module sidec_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  sidec_pkg::sidec_status_t status,
    output sidec_pkg::sidec_cmd_t    cmd
);
    import sidec_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              sign_reg, sign_next;   // sign still to be sent

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        sign_next  = sign_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                iter_next = '0;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_LAST) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.init_idx = 1'b1;
                sign_next    = status.neg;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    if (sign_reg) begin
                        cmd.emit_sign = 1'b1;
                        sign_next     = 1'b0;
                    end else begin
                        cmd.emit_digit = 1'b1;
                        if (status.last_digit) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            sign_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            sign_reg  <= sign_next;
        end
    end

endmodule
